>>> sv/lld_pkg.sv
`default_nettype none

package lld_pkg;

   // fixed field widths of the command and response words
   localparam int CMD_W     = 3;
   localparam int DATA_IN_W = 32;
   localparam int HANDLE_W  = 6;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   // defaults for the top-level parameters
   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_TAIL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

   // write strobes into the entry table
   typedef struct packed {
      logic next_we;
      logic prev_we;
      logic pay_we;
      logic use_we;
      logic free_we;
   } lld_wr_en_type;

endpackage

`default_nettype wire

>>> sv/linked_list_deque_engine_top.sv
// Response: a command taken in idle is executed in the exec state, and its response
//   word is registered onto the rsp_ ports from that state, shown for exactly one cycle.
// Busy is high for one cycle after each accept while the entry table is read and
//   written back; no new command is taken while busy. The receiver cannot stall.
// Reset (synchronous): list, free list and bump mark empty; no table clearing pass,
//   entries above the bump mark are treated as unused.
`default_nettype none

module linked_list_deque_engine_top #(
   parameter int DEPTH      = lld_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = lld_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lld_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [lld_pkg::DATA_IN_W-1:0] req_data_in,
   input  wire logic [lld_pkg::HANDLE_W-1:0]  req_handle_in,
   output logic                               rsp_strobe,
   output logic [lld_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lld_pkg::HANDLE_W-1:0]       rsp_handle_out,
   output logic [lld_pkg::DATA_IN_W-1:0]      rsp_data_out,
   output logic [lld_pkg::COUNT_W-1:0]        rsp_count_out
);
   import lld_pkg::*;

   // link fields carry DEPTH as the null marker, so they may need one bit more than an address
   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   // table write side: neighbor link at accept, entry and unlink writes in exec
   lld_wr_en_type         wr_en;
   logic [AW-1:0]         next_waddr;
   logic [IW-1:0]         next_wdata;
   logic [AW-1:0]         prev_waddr;
   logic [IW-1:0]         prev_wdata;
   logic [AW-1:0]         ent_waddr;
   logic [DATA_WIDTH-1:0] pay_wdata;
   logic                  use_wdata;
   logic [IW-1:0]         free_wdata;

   // table read side: one address issued at accept, data back in exec
   logic [AW-1:0]         raddr;
   logic [IW-1:0]         rd_next;
   logic [IW-1:0]         rd_prev;
   logic [DATA_WIDTH-1:0] rd_pay;
   logic                  rd_use;
   logic [IW-1:0]         rd_free;

   // sequencer: head/tail/count/free-list/bump registers and response word
   lld_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_data_in    (req_data_in),
      .req_handle_in  (req_handle_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_data_out   (rsp_data_out),
      .rsp_count_out  (rsp_count_out),
      .wr_en          (wr_en),
      .next_waddr     (next_waddr),
      .next_wdata     (next_wdata),
      .prev_waddr     (prev_waddr),
      .prev_wdata     (prev_wdata),
      .ent_waddr      (ent_waddr),
      .pay_wdata      (pay_wdata),
      .use_wdata      (use_wdata),
      .free_wdata     (free_wdata),
      .raddr          (raddr),
      .rd_next        (rd_next),
      .rd_prev        (rd_prev),
      .rd_pay         (rd_pay),
      .rd_use         (rd_use),
      .rd_free        (rd_free)
   );

   // entry table: links, payload, in-use marks and free-list links
   lld_table #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .ent_waddr  (ent_waddr),
      .pay_wdata  (pay_wdata),
      .use_wdata  (use_wdata),
      .free_wdata (free_wdata),
      .raddr      (raddr),
      .rd_next    (rd_next),
      .rd_prev    (rd_prev),
      .rd_pay     (rd_pay),
      .rd_use     (rd_use),
      .rd_free    (rd_free)
   );

   // every accepted word gets a response: busy in exec, then the registered strobe
   a_cmd_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 (rsp_strobe && !busy))
      else $error("accepted word did not produce a response on time");

   // no response without an exec cycle just before it
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a preceding exec cycle");

   // full is only reported once every entry is in the list
   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STAT_FULL)) |-> (rsp_count_out == COUNT_W'(DEPTH)))
      else $error("full reported with free entries left");

   // data word is zero on any command that failed
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |-> (rsp_data_out == '0))
      else $error("data returned on a failed command");

endmodule

`default_nettype wire

>>> sv/lld_table.sv
`default_nettype none

// Entry table: one array per field, one write and one registered read each.
module lld_table #(
   parameter int DEPTH      = lld_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = lld_pkg::DATA_WIDTH_DEF,
   localparam int IW = $clog2(DEPTH + 1),
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire lld_pkg::lld_wr_en_type wr_en,
   input  wire logic [AW-1:0]         next_waddr,
   input  wire logic [IW-1:0]         next_wdata,
   input  wire logic [AW-1:0]         prev_waddr,
   input  wire logic [IW-1:0]         prev_wdata,
   input  wire logic [AW-1:0]         ent_waddr,
   input  wire logic [DATA_WIDTH-1:0] pay_wdata,
   input  wire logic                  use_wdata,
   input  wire logic [IW-1:0]         free_wdata,
   input  wire logic [AW-1:0]         raddr,
   output logic [IW-1:0]              rd_next,
   output logic [IW-1:0]              rd_prev,
   output logic [DATA_WIDTH-1:0]      rd_pay,
   output logic                       rd_use,
   output logic [IW-1:0]              rd_free
);
   import lld_pkg::*;

   logic [IW-1:0]         next_mem [DEPTH];
   logic [IW-1:0]         prev_mem [DEPTH];
   logic [DATA_WIDTH-1:0] pay_mem  [DEPTH];
   logic                  use_mem  [DEPTH];
   logic [IW-1:0]         free_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (wr_en.prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (wr_en.pay_we) begin
         pay_mem[ent_waddr] <= pay_wdata;
      end
      if (wr_en.use_we) begin
         use_mem[ent_waddr] <= use_wdata;
      end
      if (wr_en.free_we) begin
         free_mem[ent_waddr] <= free_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_next <= next_mem[raddr];
      rd_prev <= prev_mem[raddr];
      rd_pay  <= pay_mem[raddr];
      rd_use  <= use_mem[raddr];
      rd_free <= free_mem[raddr];
   end

endmodule

`default_nettype wire

>>> sv/lld_ctrl.sv
`default_nettype none

// Command sequencer: issue read on accept, read-modify-write in exec.
module lld_ctrl #(
   parameter int DEPTH      = lld_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = lld_pkg::DATA_WIDTH_DEF,
   localparam int IW = $clog2(DEPTH + 1),
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lld_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [lld_pkg::DATA_IN_W-1:0] req_data_in,
   input  wire logic [lld_pkg::HANDLE_W-1:0]  req_handle_in,
   output logic                               rsp_strobe,
   output logic [lld_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lld_pkg::HANDLE_W-1:0]       rsp_handle_out,
   output logic [lld_pkg::DATA_IN_W-1:0]      rsp_data_out,
   output logic [lld_pkg::COUNT_W-1:0]        rsp_count_out,
   output lld_pkg::lld_wr_en_type             wr_en,
   output logic [AW-1:0]                      next_waddr,
   output logic [IW-1:0]                      next_wdata,
   output logic [AW-1:0]                      prev_waddr,
   output logic [IW-1:0]                      prev_wdata,
   output logic [AW-1:0]                      ent_waddr,
   output logic [DATA_WIDTH-1:0]              pay_wdata,
   output logic                               use_wdata,
   output logic [IW-1:0]                      free_wdata,
   output logic [AW-1:0]                      raddr,
   input  wire logic [IW-1:0]                 rd_next,
   input  wire logic [IW-1:0]                 rd_prev,
   input  wire logic [DATA_WIDTH-1:0]         rd_pay,
   input  wire logic                          rd_use,
   input  wire logic [IW-1:0]                 rd_free
);
   import lld_pkg::*;

   localparam int KW = (IW > HANDLE_W) ? IW : HANDLE_W;
   localparam logic [IW-1:0] NIL = IW'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [KW-1:0]         key_ff, key_in;
   logic [IW-1:0]         free_head_ff, free_head_in;
   logic [IW-1:0]         bump_ff, bump_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [IW-1:0]         tail_ff, tail_in;
   logic [IW-1:0]         count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [DATA_IN_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic          accept;
   logic          from_free;
   logic          alloc_ok;
   logic [IW-1:0] alloc_e;
   logic          hit;
   logic [IW-1:0] victim;

   always_comb begin
      accept    = start && (state_ff == S_IDLE);
      from_free = (free_head_ff != NIL);
      alloc_e   = from_free ? free_head_ff : bump_ff;
      alloc_ok  = from_free || (bump_ff != NIL);

      // index to look up: free-list top, handle or tail
      case (req_cmd)
         CMD_ADD_HEAD, CMD_ADD_TAIL: key_in = KW'(free_head_ff);
         CMD_DELETE:                 key_in = KW'(req_handle_in);
         CMD_POP_TAIL:               key_in = KW'(tail_ff);
         default:                    key_in = '0;
      endcase
      raddr = (key_in < KW'(DEPTH)) ? AW'(key_in) : '0;

      // entry live only below the bump mark; above it in_use is stale
      hit    = (key_ff < KW'(bump_ff)) && rd_use;
      victim = IW'(key_ff);

      state_in      = state_ff;
      free_head_in  = free_head_ff;
      bump_in       = bump_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rsp_strobe_in = (state_ff == S_EXEC);
      rsp_status_in = STAT_OK;
      rsp_handle_in = '0;
      rsp_data_in   = '0;

      wr_en      = '0;
      next_waddr = '0;
      next_wdata = '0;
      prev_waddr = '0;
      prev_wdata = '0;
      ent_waddr  = '0;
      pay_wdata  = data_ff;
      use_wdata  = 1'b0;
      free_wdata = free_head_ff;

      if (accept) begin
         state_in = S_EXEC;
         // neighbor link is written right away to free the port for exec
         if (alloc_ok) begin
            case (req_cmd)
               CMD_ADD_HEAD: begin
                  if (head_ff != NIL) begin
                     wr_en.prev_we = 1'b1;
                     prev_waddr    = AW'(head_ff);
                     prev_wdata    = alloc_e;
                  end
               end
               CMD_ADD_TAIL: begin
                  if (tail_ff != NIL) begin
                     wr_en.next_we = 1'b1;
                     next_waddr    = AW'(tail_ff);
                     next_wdata    = alloc_e;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (state_ff == S_EXEC) begin
         state_in = S_IDLE;
         case (cmd_ff)
            CMD_ADD_HEAD, CMD_ADD_TAIL: begin
               if (!alloc_ok) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  if (from_free) begin
                     free_head_in = (rd_free > NIL) ? NIL : rd_free;
                  end else begin
                     bump_in = bump_ff + IW'(1);
                  end
                  wr_en.pay_we  = 1'b1;
                  wr_en.use_we  = 1'b1;
                  wr_en.next_we = 1'b1;
                  wr_en.prev_we = 1'b1;
                  ent_waddr     = AW'(alloc_e);
                  use_wdata     = 1'b1;
                  next_waddr    = AW'(alloc_e);
                  prev_waddr    = AW'(alloc_e);
                  if (cmd_ff == CMD_ADD_HEAD) begin
                     prev_wdata = NIL;
                     next_wdata = head_ff;
                     head_in    = alloc_e;
                     if (tail_ff == NIL) begin
                        tail_in = alloc_e;
                     end
                  end else begin
                     next_wdata = NIL;
                     prev_wdata = tail_ff;
                     tail_in    = alloc_e;
                     if (head_ff == NIL) begin
                        head_in = alloc_e;
                     end
                  end
                  count_in      = count_ff + IW'(1);
                  rsp_handle_in = HANDLE_W'(alloc_e);
               end
            end
            CMD_DELETE, CMD_POP_TAIL: begin
               if (!hit) begin
                  rsp_status_in = (cmd_ff == CMD_DELETE) ? STAT_BAD : STAT_EMPTY;
               end else begin
                  // unlink victim and push it onto the free list
                  if (rd_prev < NIL) begin
                     wr_en.next_we = 1'b1;
                     next_waddr    = AW'(rd_prev);
                     next_wdata    = rd_next;
                  end else begin
                     head_in = (rd_next < NIL) ? rd_next : NIL;
                  end
                  if (rd_next < NIL) begin
                     wr_en.prev_we = 1'b1;
                     prev_waddr    = AW'(rd_next);
                     prev_wdata    = rd_prev;
                  end else begin
                     tail_in = (rd_prev < NIL) ? rd_prev : NIL;
                  end
                  wr_en.use_we  = 1'b1;
                  wr_en.free_we = 1'b1;
                  ent_waddr     = AW'(victim);
                  use_wdata     = 1'b0;
                  free_wdata    = free_head_ff;
                  free_head_in  = victim;
                  count_in      = (count_ff != '0) ? count_ff - IW'(1) : '0;
                  if (cmd_ff == CMD_POP_TAIL) begin
                     rsp_data_in = DATA_IN_W'(rd_pay);
                  end
               end
            end
            CMD_FLUSH: begin
               free_head_in = NIL;
               bump_in      = '0;
               head_in      = NIL;
               tail_in      = NIL;
               count_in     = '0;
            end
            default: begin
            end
         endcase
      end

      rsp_count_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= NIL;
         bump_ff       <= '0;
         head_ff       <= NIL;
         tail_ff       <= NIL;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         bump_ff       <= bump_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         data_ff <= DATA_WIDTH'(req_data_in);
         key_ff  <= key_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy           = (state_ff == S_EXEC);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_count_out  = rsp_count_ff;

endmodule

`default_nettype wire

>>> tb/linked_list_deque_engine_top_test.sv
`timescale 1ns / 100ps

module linked_list_deque_engine_top_test;
   import lld_pkg::*;

   localparam int DEPTH    = DEPTH_DEF;
   localparam int N_RANDOM = 1500;
   localparam int MAX_SHOWN = 10;
   // Null link: one past the last table entry, same convention as the block.
   localparam logic [6:0] NIL = 7'(DEPTH);
   // Command codes with no function; the block must answer ok and leave the list alone.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [DATA_IN_W-1:0] data;
      logic [HANDLE_W-1:0]  handle;
   } cmd_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [HANDLE_W-1:0]  handle;
      logic [DATA_IN_W-1:0] data;
      logic [COUNT_W-1:0]   count;
   } rsp_word_type;

   // DUT ports; every input has a known value from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [DATA_IN_W-1:0] req_data_in = '0;
   logic [HANDLE_W-1:0]  req_handle_in = '0;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [HANDLE_W-1:0]  rsp_handle_out;
   logic [DATA_IN_W-1:0] rsp_data_out;
   logic [COUNT_W-1:0]   rsp_count_out;

   // Shadow copy of the entry table and list pointers.
   logic [6:0]           fwd_link  [DEPTH];
   logic [6:0]           back_link [DEPTH];
   logic [DATA_IN_W-1:0] slot_data [DEPTH];
   logic                 slot_used [DEPTH];
   logic [6:0]           free_link [DEPTH];
   logic [6:0]           free_top;
   logic [6:0]           bump_mark;
   logic [6:0]           head_slot;
   logic [6:0]           tail_slot;
   logic [6:0]           live_count;

   // Commands waiting for the driver, and responses the list should produce next.
   cmd_word_type cmd_backlog [$];
   rsp_word_type rsp_due [$];

   logic word_taken = 1'b0;   // start && !busy seen at the last rising edge
   int   sender_idle_pct = 9;
   int   words_queued = 0;
   int   words_taken = 0;
   int   err_count = 0;
   int   peak_fill = 0;
   int   cmd_seen [8];
   int   status_seen [4];

   always #10 clock = ~clock;

   linked_list_deque_engine_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_data_in    (req_data_in),
      .req_handle_in  (req_handle_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_data_out   (rsp_data_out),
      .rsp_count_out  (rsp_count_out)
   );

   // ---------------------------------------------------------------- predictor

   // Take an entry out of the list and push it on the free list.
   function automatic void unlink_slot(logic [6:0] e);
      logic [6:0] p;
      logic [6:0] n;
      p = back_link[e];
      n = fwd_link[e];
      if (p < NIL) fwd_link[p] = n;
      else head_slot = (n < NIL) ? n : NIL;
      if (n < NIL) back_link[n] = p;
      else tail_slot = (p < NIL) ? p : NIL;
      slot_used[e] = 1'b0;
      free_link[e] = free_top;
      free_top = e;
      if (live_count > 0) live_count--;
   endfunction

   // Apply one command to the shadow list and return the response it should give.
   function automatic rsp_word_type apply_list_cmd(cmd_word_type w);
      rsp_word_type r;
      logic [6:0]   e;
      r = '0;
      r.status = STAT_OK;
      case (w.cmd)
         CMD_ADD_HEAD, CMD_ADD_TAIL: begin
            // free list first, then never-used entries from the bump mark
            e = NIL;
            if (free_top < NIL) begin
               e = free_top;
               free_top = (free_link[e] > NIL) ? NIL : free_link[e];
            end else if (bump_mark < NIL) begin
               e = bump_mark;
               bump_mark++;
            end
            if (e == NIL) begin
               r.status = STAT_FULL;
            end else begin
               slot_data[e] = w.data;
               slot_used[e] = 1'b1;
               if (w.cmd == CMD_ADD_HEAD) begin
                  back_link[e] = NIL;
                  fwd_link[e] = head_slot;
                  if (head_slot < NIL) back_link[head_slot] = e;
                  head_slot = e;
                  if (tail_slot >= NIL) tail_slot = e;
               end else begin
                  fwd_link[e] = NIL;
                  back_link[e] = tail_slot;
                  if (tail_slot < NIL) fwd_link[tail_slot] = e;
                  tail_slot = e;
                  if (head_slot >= NIL) head_slot = e;
               end
               live_count++;
               r.handle = e[5:0];
            end
         end
         CMD_DELETE: begin
            if (slot_used[w.handle]) unlink_slot(7'(w.handle));
            else r.status = STAT_BAD;
         end
         CMD_POP_TAIL: begin
            if (tail_slot < NIL && slot_used[tail_slot]) begin
               r.data = slot_data[tail_slot];
               unlink_slot(tail_slot);
            end else begin
               r.status = STAT_EMPTY;
            end
         end
         CMD_FLUSH: begin
            for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
            free_top = NIL;
            bump_mark = '0;
            head_slot = NIL;
            tail_slot = NIL;
            live_count = '0;
         end
         default: ;   // spare codes: no effect
      endcase
      r.count = COUNT_W'(live_count);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Payload mix: corners, single bits and plain random words.
   function automatic logic [DATA_IN_W-1:0] pick_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // A handle currently in the list, scanning from a random spot; any handle if empty.
   function automatic logic [HANDLE_W-1:0] pick_live_handle();
      int base;
      base = $urandom_range(0, DEPTH - 1);
      for (int i = 0; i < DEPTH; i++)
         if (slot_used[(base + i) % DEPTH]) return HANDLE_W'((base + i) % DEPTH);
      return HANDLE_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // Keep the backlog short so handle picks track the live list closely.
   task automatic queue_word(logic [CMD_W-1:0] c, logic [DATA_IN_W-1:0] d,
                             logic [HANDLE_W-1:0] h);
      while (cmd_backlog.size() > 1) @(negedge clock);
      cmd_backlog.push_back('{cmd: c, data: d, handle: h});
      words_queued++;
   endtask

   // Hold off until every queued word is taken and every response is back.
   task automatic wait_quiet();
      while (words_taken != words_queued || rsp_due.size() != 0) @(negedge clock);
   endtask

   task automatic flag_error(string msg);
      err_count++;
      if (err_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------- driver

   // Falling edge: hold a word until it is taken, then maybe present the next one.
   always @(negedge clock) begin
      cmd_word_type nxt;
      logic         go;
      go = start && !word_taken;
      if (!reset && !go && cmd_backlog.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
         nxt = cmd_backlog.pop_front();
         req_cmd <= nxt.cmd;
         req_data_in <= nxt.data;
         req_handle_in <= nxt.handle;
         go = 1'b1;
      end
      start <= go;
   end

   // ---------------------------------------------------------------- monitor

   // Rising edge: check any response against the oldest prediction, then predict
   // for a word taken at this edge. Only one word is in flight at a time, so the order holds.
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      cmd_word_type taken;
      word_taken <= !reset && start && !busy;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            fwd_link[i] = '0;
            back_link[i] = '0;
            slot_data[i] = '0;
            slot_used[i] = 1'b0;
            free_link[i] = '0;
         end
         free_top = NIL;
         bump_mark = '0;
         head_slot = NIL;
         tail_slot = NIL;
         live_count = '0;
      end else begin
         if (rsp_strobe) begin
            got = '{status: rsp_status, handle: rsp_handle_out, data: rsp_data_out,
                    count: rsp_count_out};
            if (rsp_due.size() == 0) begin
               flag_error($sformatf("unexpected word: st=%0d h=%0d d=%h cnt=%0d",
                                    got.status, got.handle, got.data, got.count));
            end else begin
               want = rsp_due.pop_front();
               if (got.status !== want.status || got.handle !== want.handle ||
                   got.data !== want.data || got.count !== want.count)
                  flag_error($sformatf({"mismatch: exp st=%0d h=%0d d=%h cnt=%0d,",
                                        " got st=%0d h=%0d d=%h cnt=%0d"},
                                       want.status, want.handle, want.data, want.count,
                                       got.status, got.handle, got.data, got.count));
               status_seen[want.status]++;
               if (want.count > peak_fill) peak_fill = want.count;
            end
         end
         if (start && !busy) begin
            taken = '{cmd: req_cmd, data: req_data_in, handle: req_handle_in};
            rsp_due.push_back(apply_list_cmd(taken));
            cmd_seen[taken.cmd]++;
            words_taken++;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int               n;
      int               phase;
      int               burst_left;
      int               add_pct;
      logic             fill_next;
      logic [CMD_W-1:0] c;
      logic [6:0]       nh;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty pops, bad handles, head and middle deletes, tail pops, free-list
      // reuse, spare codes, flush and bump reuse after flush.
      queue_word(CMD_POP_TAIL, pick_data(), 6'd0);
      queue_word(CMD_DELETE, pick_data(), 6'd0);
      queue_word(CMD_DELETE, pick_data(), 6'd63);
      queue_word(CMD_ADD_HEAD, 32'h0000_0000, 6'd63);
      queue_word(CMD_ADD_TAIL, 32'hFFFF_FFFF, 6'd0);
      queue_word(CMD_ADD_HEAD, 32'hA5A5_A5A5, 6'd0);
      queue_word(CMD_ADD_TAIL, 32'h5A5A_5A5A, 6'd0);   // list is 2,0,1,3
      queue_word(CMD_DELETE, pick_data(), 6'd1);        // middle entry
      queue_word(CMD_DELETE, pick_data(), 6'd1);        // now on the free list
      queue_word(CMD_ADD_TAIL, pick_data(), 6'd0);     // reuses entry 1
      queue_word(CMD_DELETE, pick_data(), 6'd2);        // head entry
      queue_word(CMD_POP_TAIL, pick_data(), 6'd0);
      queue_word(CMD_POP_TAIL, pick_data(), 6'd0);
      queue_word(CMD_SPARE_LO, pick_data(), 6'd0);
      queue_word(CMD_SPARE_LO + CMD_W'(1), pick_data(), 6'd63);
      queue_word(CMD_SPARE_HI, pick_data(), 6'd0);
      queue_word(CMD_FLUSH, pick_data(), 6'd0);
      queue_word(CMD_POP_TAIL, pick_data(), 6'd0);
      queue_word(CMD_DELETE, pick_data(), 6'd0);
      queue_word(CMD_ADD_HEAD, pick_data(), 6'd0);     // bump restarts at 0
      queue_word(CMD_ADD_TAIL, pick_data(), 6'd0);
      queue_word(CMD_DELETE, pick_data(), 6'd0);        // head with a successor
      queue_word(CMD_POP_TAIL, pick_data(), 6'd0);      // last one out
      queue_word(CMD_ADD_TAIL, pick_data(), 6'd0);

      // Sender holds off until the block has drained.
      wait_quiet();

      // Random: bursts that fill, drain or churn the list, so full and empty
      // both get hit; each third opens with a fill burst.
      n = 0;
      phase = 0;
      burst_left = 0;
      fill_next = 1'b1;
      add_pct = 50;
      while (n < N_RANDOM) begin
         if (phase < 2 && n >= (phase + 1) * (N_RANDOM / 3)) begin
            wait_quiet();
            phase++;
            sender_idle_pct = (phase == 1) ? 68 : 0;
            burst_left = 0;
            fill_next = 1'b1;
         end
         if (burst_left == 0) begin
            if (!fill_next && $urandom_range(0, 5) == 0) begin
               queue_word(CMD_FLUSH, pick_data(), HANDLE_W'($urandom));
               n++;
            end
            if (fill_next) begin
               add_pct = 85;
               burst_left = 90;
               fill_next = 1'b0;
            end else begin
               case ($urandom_range(0, 2))
                  0: add_pct = 85;
                  1: add_pct = 20;
                  default: add_pct = 50;
               endcase
               burst_left = $urandom_range(20, 120);
            end
         end
         burst_left--;
         if ($urandom_range(0, 99) < 2) begin
            // ignored by the block; not counted
            c = CMD_SPARE_LO + CMD_W'($urandom_range(0, CMD_SPARE_HI - CMD_SPARE_LO));
            queue_word(c, pick_data(), HANDLE_W'($urandom));
         end else begin
            if ($urandom_range(0, 99) < add_pct)
               c = $urandom_range(0, 1) ? CMD_ADD_HEAD : CMD_ADD_TAIL;
            else
               c = $urandom_range(0, 1) ? CMD_POP_TAIL : CMD_DELETE;
            if (c == CMD_DELETE && $urandom_range(0, 4) != 0)
               queue_word(c, pick_data(), pick_live_handle());
            else
               queue_word(c, pick_data(), HANDLE_W'($urandom));
            n++;
         end
      end

      // Drain, then idle before the summary so anything stray shows up.
      wait_quiet();
      repeat (8) @(negedge clock);

      $display({"Covered %0d commands: %0d add head, %0d add tail, %0d delete,",
                " %0d pop, %0d flush, %0d spare; peak fill %0d of %0d"},
               words_taken, cmd_seen[CMD_ADD_HEAD], cmd_seen[CMD_ADD_TAIL],
               cmd_seen[CMD_DELETE], cmd_seen[CMD_POP_TAIL], cmd_seen[CMD_FLUSH],
               cmd_seen[5] + cmd_seen[6] + cmd_seen[7], peak_fill, DEPTH);
      $display("Status mix: %0d ok, %0d empty, %0d full, %0d bad handle; %0d errors",
               status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
               status_seen[STAT_BAD], err_count);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: set far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timeout: %0d of %0d commands taken, %0d responses outstanding",
               words_taken, words_queued, rsp_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
